// ===== rtl/multichannel_minmax_mid_voltmeter_macros.svh =====
// assertion macros shared by the voltmeter rtl
// expects i_clk and i_rst_n in the scope of every use
`ifndef MULTICHANNEL_MINMAX_MID_VOLTMETER_MACROS_SVH
`define MULTICHANNEL_MINMAX_MID_VOLTMETER_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define VMM_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("vmm assertion failed");
// expression must never be true outside reset
`define VMM_ASSERT_NEVER(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error("vmm forbidden condition seen");
`else
`define VMM_ASSERT(lbl, prop)
`define VMM_ASSERT_NEVER(lbl, expr)
`endif

`endif

// ===== rtl/vmm_pkg.sv =====
// shared types and constants of the min/max midpoint voltmeter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package vmm_pkg;

    localparam int REG_CH     = 4;      // channels with config registers
    localparam int CH_W       = 2;
    localparam int OFF_W      = 10;
    localparam int SCALE_W    = 16;
    localparam int TRK_W      = 11;
    localparam int FRAC_W     = 16;
    localparam int PROD_W     = 32;
    localparam int WHOLE_W    = 8;
    localparam int HUND_W     = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int STATE_MAX = 2047;
    localparam logic [TRK_W-1:0]   MIN_RESET = 11'd2000;
    localparam logic [WHOLE_W-1:0] WHOLE_MAX = 8'd255;
    localparam logic [SCALE_W-1:0] HUNDRED   = 16'd100;

    // register index of the first scale register, offsets sit below it
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_CH0 = 3'd4;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_EOW    = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SAMPLE,
        S_MID,
        S_MULA,
        S_MULB,
        S_LOAD,
        S_WAIT
    } t_state;

    typedef enum logic {
        MUL_MID_SCALE,
        MUL_FRAC_HUNDRED
    } t_mul_sel;

    typedef struct packed {
        logic            in_ready;
        logic            upd_trk;
        logic            ld_mid;
        logic            mul_en;
        t_mul_sel        mul_sel;
        logic            ld_whole;
        logic            ld_out;
        logic            clr_trk;
        logic [CH_W-1:0] ch;
        logic            last;
    } t_ctrl;

endpackage

`default_nettype wire

// ===== rtl/vmm_mul.sv =====
// shared multiplier: midpoint times scale, then fraction times one hundred
// depends on vmm_pkg
`timescale 1ns / 1ps
`default_nettype none

module vmm_mul (
    input  wire logic                         i_clk,
    input  wire logic                         i_en,
    input  wire vmm_pkg::t_mul_sel            i_sel,
    input  wire logic [vmm_pkg::SCALE_W-1:0]  i_scale,
    input  wire logic [vmm_pkg::TRK_W-1:0]    i_mid,
    output logic      [vmm_pkg::PROD_W-1:0]   o_prod
);
    import vmm_pkg::*;

    logic [PROD_W-1:0]  r_prod;
    logic [SCALE_W-1:0] op_a;
    logic [SCALE_W-1:0] op_b;

    always_comb begin
        case (i_sel)
            MUL_MID_SCALE: begin
                op_a = i_scale;
                op_b = SCALE_W'(i_mid);
            end
            MUL_FRAC_HUNDRED: begin
                op_a = r_prod[FRAC_W-1:0];
                op_b = HUNDRED;
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= PROD_W'(op_a) * PROD_W'(op_b);
        end
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

// ===== rtl/vmm_ctrl.sv =====
// sequencer: sample update and per-channel walk at end of window
// depends on vmm_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "multichannel_minmax_mid_voltmeter_macros.svh"

module vmm_ctrl #(
    parameter int SERVED = 4
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire logic           i_opcode,
    input  wire logic           i_out_accept,
    output vmm_pkg::t_ctrl      o_ctrl
);
    import vmm_pkg::*;

    t_state          r_state;
    t_state          n_state;
    logic [CH_W-1:0] r_ch;
    logic [CH_W-1:0] n_ch;
    logic            last;

    assign last = (r_ch == CH_W'(SERVED - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_opcode == OP_EOW) ? S_MID : S_SAMPLE;
                end
            end
            S_SAMPLE: n_state = S_IDLE;
            S_MID:    n_state = S_MULA;
            S_MULA:   n_state = S_MULB;
            S_MULB:   n_state = S_LOAD;
            S_LOAD:   n_state = S_WAIT;
            S_WAIT: begin
                if (i_out_accept) begin
                    n_state = last ? S_IDLE : S_MID;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_ch = r_ch;
        if (r_state == S_IDLE && i_in_valid) begin
            n_ch = '0;
        end else if (r_state == S_WAIT && i_out_accept && !last) begin
            n_ch = r_ch + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ch    <= '0;
        end else begin
            r_state <= n_state;
            r_ch    <= n_ch;
        end
    end

    always_comb begin
        o_ctrl          = '0;
        o_ctrl.mul_sel  = MUL_MID_SCALE;
        o_ctrl.ch       = r_ch;
        o_ctrl.last     = last;
        unique case (r_state)
            S_IDLE:   o_ctrl.in_ready = 1'b1;
            S_SAMPLE: o_ctrl.upd_trk  = 1'b1;
            S_MID:    o_ctrl.ld_mid   = 1'b1;
            S_MULA:   o_ctrl.mul_en   = 1'b1;
            S_MULB: begin
                o_ctrl.mul_en   = 1'b1;
                o_ctrl.mul_sel  = MUL_FRAC_HUNDRED;
                o_ctrl.ld_whole = 1'b1;
            end
            S_LOAD: begin
                o_ctrl.ld_out  = 1'b1;
                o_ctrl.clr_trk = last;
            end
            S_WAIT:   ;
            default:  ;
        endcase
    end

    `VMM_ASSERT(a_ch_in_range, r_ch <= CH_W'(SERVED - 1))
    `VMM_ASSERT(a_walk_steps, r_state == S_MID |=> r_state == S_MULA)
    `VMM_ASSERT(a_wait_holds, r_state == S_WAIT && !i_out_accept |=> r_state == S_WAIT)

endmodule

`default_nettype wire

// ===== rtl/multichannel_minmax_mid_voltmeter.sv =====
// a sample item is captured when taken and folded into its tracker in the next cycle;
//   no new item is taken until the fold is done; an end-of-window item walks each served
//   channel through midpoint, two multiplies and result load, then waits while the result is stalled
// the shared multiplier runs twice per channel (midpoint*scale, fraction*100)
// reset (synchronous, active low) clears config registers to 0, max trackers to 0
//   and min trackers to 2000; the block is ready right after reset
`timescale 1ns / 1ps
`default_nettype none
`include "multichannel_minmax_mid_voltmeter_macros.svh"

module multichannel_minmax_mid_voltmeter #(
    parameter int NUM_CHANNELS = 4,
    parameter int SAMPLE_BITS  = 10
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // config write port
    input  wire logic                            i_cfg_we,
    input  wire logic [vmm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [vmm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // input items
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic                            i_opcode,
    input  wire logic [vmm_pkg::CH_W-1:0]        i_channel,
    input  wire logic [SAMPLE_BITS-1:0]          i_sample,
    // result items
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic      [vmm_pkg::CH_W-1:0]        o_out_channel,
    output logic      [vmm_pkg::WHOLE_W-1:0]     o_volts_whole,
    output logic      [vmm_pkg::HUND_W-1:0]      o_volts_hundredths,
    output logic      [vmm_pkg::TRK_W-1:0]       o_midpoint,
    output logic                                 o_last
);
    import vmm_pkg::*;

    // channels with both trackers and registers
    localparam int SERVED = (NUM_CHANNELS < REG_CH) ? NUM_CHANNELS : REG_CH;
    localparam int SRV_W  = CH_W + 1;
    // sample plus offset before saturation
    localparam int SUM_W  = ((SAMPLE_BITS > OFF_W) ? SAMPLE_BITS : OFF_W) + 1;

    t_ctrl ctrl;

    // config registers
    logic [OFF_W-1:0]   r_offset [REG_CH];
    logic [SCALE_W-1:0] r_scale  [REG_CH];

    // window trackers
    logic [TRK_W-1:0] r_max [REG_CH];
    logic [TRK_W-1:0] r_min [REG_CH];

    // captured sample item
    logic [CH_W-1:0]  r_in_ch;
    logic [TRK_W-1:0] r_in_val;
    logic             r_in_ok;

    // walk datapath
    logic [TRK_W-1:0]   r_mid;
    logic [WHOLE_W-1:0] r_whole;
    logic [PROD_W-1:0]  prod;

    // result register
    logic               r_out_valid;
    logic [CH_W-1:0]    r_out_ch;
    logic [WHOLE_W-1:0] r_out_whole;
    logic [HUND_W-1:0]  r_out_hund;
    logic [TRK_W-1:0]   r_out_mid;
    logic               r_out_last;

    logic             in_accept;
    logic             out_accept;
    logic [SUM_W-1:0] sum;
    logic [TRK_W-1:0] sat_val;
    logic             ch_ok;
    logic [CH_W-1:0]  rd_idx;
    logic [TRK_W-1:0] rd_max;
    logic [TRK_W-1:0] rd_min;
    logic [TRK_W:0]   mid_sum;

    assign in_accept  = i_in_valid & ctrl.in_ready;
    assign out_accept = r_out_valid & ~i_out_stall;
    assign o_in_stall = ~ctrl.in_ready;

    vmm_ctrl #(
        .SERVED (SERVED)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_opcode     (i_opcode),
        .i_out_accept (out_accept),
        .o_ctrl       (ctrl)
    );

    vmm_mul u_mul (
        .i_clk   (i_clk),
        .i_en    (ctrl.mul_en),
        .i_sel   (ctrl.mul_sel),
        .i_scale (r_scale[ctrl.ch]),
        .i_mid   (r_mid),
        .o_prod  (prod)
    );

    // config writes; offsets below the first scale index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < REG_CH; i++) begin
                r_offset[i] <= '0;
                r_scale[i]  <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx < REG_SCALE_CH0) begin
                r_offset[i_cfg_idx[CH_W-1:0]] <= i_cfg_data[OFF_W-1:0];
            end else begin
                r_scale[i_cfg_idx[CH_W-1:0]] <= i_cfg_data[SCALE_W-1:0];
            end
        end
    end

    // raw zero snaps to zero, otherwise add offset and clip to tracker range
    always_comb begin
        sum = (i_sample == '0) ? '0 : (SUM_W'(i_sample) + SUM_W'(r_offset[i_channel]));
        sat_val = (sum > SUM_W'(STATE_MAX)) ? TRK_W'(STATE_MAX) : sum[TRK_W-1:0];
        ch_ok   = ({1'b0, i_channel} < SRV_W'(SERVED));
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_ch  <= i_channel;
            r_in_val <= sat_val;
            r_in_ok  <= ch_ok & (i_opcode == OP_SAMPLE);
        end
    end

    // one tracker read port, shared by sample update and window walk
    assign rd_idx  = ctrl.upd_trk ? r_in_ch : ctrl.ch;
    assign rd_max  = r_max[rd_idx];
    assign rd_min  = r_min[rd_idx];
    assign mid_sum = {1'b0, rd_max} + {1'b0, rd_min};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || ctrl.clr_trk) begin
            for (int i = 0; i < REG_CH; i++) begin
                r_max[i] <= '0;
                r_min[i] <= MIN_RESET;
            end
        end else if (ctrl.upd_trk && r_in_ok) begin
            if (r_in_val > rd_max) begin
                r_max[rd_idx] <= r_in_val;
            end
            if (r_in_val < rd_min) begin
                r_min[rd_idx] <= r_in_val;
            end
        end
    end

    // midpoint, then whole volts from the first product
    always_ff @(posedge i_clk) begin
        if (ctrl.ld_mid) begin
            r_mid <= mid_sum[TRK_W:1];
        end
        if (ctrl.ld_whole) begin
            r_whole <= (|prod[PROD_W-1:FRAC_W+WHOLE_W]) ? WHOLE_MAX
                                                         : prod[FRAC_W+WHOLE_W-1:FRAC_W];
        end
    end

    // result register; hundredths come from the second product
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.ld_out) begin
            r_out_valid <= 1'b1;
        end else if (out_accept) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.ld_out) begin
            r_out_ch    <= ctrl.ch;
            r_out_whole <= r_whole;
            r_out_hund  <= prod[FRAC_W+HUND_W-1:FRAC_W];
            r_out_mid   <= r_mid;
            r_out_last  <= ctrl.last;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_out_channel      = r_out_ch;
    assign o_volts_whole      = r_out_whole;
    assign o_volts_hundredths = r_out_hund;
    assign o_midpoint         = r_out_mid;
    assign o_last             = r_out_last;

    `VMM_ASSERT(a_no_input_while_result, r_out_valid |-> o_in_stall)
    `VMM_ASSERT(a_hund_range, r_out_valid |-> (r_out_hund < HUND_W'(100)))
    `VMM_ASSERT(a_gap_between_results, out_accept && !r_out_last |=> !r_out_valid)
    `VMM_ASSERT_NEVER(a_load_over_result, ctrl.ld_out && r_out_valid)

endmodule

`default_nettype wire
